// ----- hw/rtl/atf_pkg.sv -----
// Shared types and constants for the animated-texture frame table.
// Word layouts, command codes, controller states and control/status bundles.
// No dependencies.
`default_nettype none

package atf_pkg;

   // command codes, same encoding on request and response
   localparam logic [2:0] CMD_ALLOC   = 3'd0;
   localparam logic [2:0] CMD_SET     = 3'd1;
   localparam logic [2:0] CMD_RELEASE = 3'd2;
   localparam logic [2:0] CMD_QUERY   = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;

   localparam int unsigned PHASE_W  = 25;
   localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

   // request word, lowest field in the lowest bits (64 bits)
   typedef struct packed {
      logic [15:0] delta_time;
      logic [7:0]  frame_count;
      logic [15:0] frm_speed;
      logic [15:0] frm_bytes;
      logic [1:0]  slot;
      logic [2:0]  list_index;
      logic [2:0]  cmd;
   } req_word_type;

   // response word, padded to 40 bits
   typedef struct packed {
      logic [6:0]         pad;
      logic               table_full;
      logic [PHASE_W-1:0] tex_ofs;
      logic               hit;
      logic [2:0]         result_index;
      logic [2:0]         done_cmd;
   } rsp_word_type;

   // one slot entry as held in the slot RAM (Q9.16 phase)
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [7:0]         count;
      logic [15:0]        rate;
      logic [15:0]        size;
   } slot_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ALLOC_SCAN,
      ST_ALLOC_CLR,
      ST_QUERY_RD,
      ST_TICK_RD,
      ST_TICK_MUL,
      ST_TICK_WR,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic ld_first;
      logic scan_step;
      logic slot_step;
      logic clr_step;
      logic alloc_mark;
      logic set_full;
      logic release_list;
      logic wr_set;
      logic wr_zero;
      logic wr_tick;
      logic rd_query;
      logic rd_tick;
      logic mul_query;
      logic mul_tick;
      logic rsp_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] cmd;
      logic       addr_ok;
      logic       lst_alive;
      logic       lst_last;
      logic       slt_last;
      logic       addr_last;
      logic       rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/atf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Contents undefined after reset. No dependencies.
`default_nettype none

module atf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/atf_ctrl.sv -----
// Sequencing state machine for the frame table.
// Drives ctrl_cmd_type strobes into the datapath; uses atf_pkg.
`default_nettype none

module atf_ctrl
   import atf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.addr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.cmd)
               CMD_ALLOC: state_in = ST_ALLOC_SCAN;
               CMD_QUERY: state_in = ST_QUERY_RD;
               CMD_TICK:  state_in = ST_TICK_RD;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_ALLOC_SCAN: begin
            if (!status.lst_alive)     state_in = ST_ALLOC_CLR;
            else if (status.lst_last)  state_in = ST_FINISH;
         end
         ST_ALLOC_CLR: begin
            if (status.slt_last) state_in = ST_FINISH;
         end
         ST_QUERY_RD: state_in = ST_FINISH;
         ST_TICK_RD: begin
            if (status.lst_alive)                         state_in = ST_TICK_MUL;
            else if (status.lst_last && status.slt_last)  state_in = ST_FINISH;
         end
         ST_TICK_MUL: state_in = ST_TICK_WR;
         ST_TICK_WR: begin
            if (status.lst_last && status.slt_last) state_in = ST_FINISH;
            else                                    state_in = ST_TICK_RD;
         end
         ST_FINISH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_zero  = 1'b1;
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECODE: begin
            case (status.cmd)
               CMD_ALLOC:   cmd.ld_first     = 1'b1;
               CMD_SET:     cmd.wr_set       = status.addr_ok;
               CMD_RELEASE: cmd.release_list = 1'b1;
               CMD_QUERY:   cmd.rd_query     = 1'b1;
               CMD_TICK:    cmd.ld_first     = 1'b1;
               default: ;
            endcase
         end
         ST_ALLOC_SCAN: begin
            if (!status.lst_alive)    cmd.alloc_mark = 1'b1;
            else if (status.lst_last) cmd.set_full   = 1'b1;
            else                      cmd.scan_step  = 1'b1;
         end
         ST_ALLOC_CLR: begin
            cmd.wr_zero   = 1'b1;
            cmd.slot_step = !status.slt_last;
         end
         ST_QUERY_RD: cmd.mul_query = 1'b1;
         ST_TICK_RD: begin
            if (status.lst_alive) cmd.rd_tick   = 1'b1;
            else                  cmd.slot_step = 1'b1;
         end
         ST_TICK_MUL: cmd.mul_tick = 1'b1;
         ST_TICK_WR: begin
            cmd.wr_tick   = 1'b1;
            cmd.slot_step = 1'b1;
         end
         ST_FINISH: cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/atf_dpath.sv -----
// Datapath of the frame table: request capture, walk counters, live bits,
// slot RAM, shared 16x16 multiplier, phase update and response register.
// Uses atf_pkg and atf_ram.
`default_nettype none

module atf_dpath
   import atf_pkg::*;
#(
   parameter int unsigned NUM_LISTS      = 8,
   parameter int unsigned SLOTS_PER_LIST = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [63:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [39:0]  rsp_tdata,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status
);

   localparam int unsigned TOTAL = NUM_LISTS * SLOTS_PER_LIST;
   localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int unsigned LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int unsigned SW    = (SLOTS_PER_LIST > 1) ? $clog2(SLOTS_PER_LIST) : 1;
   localparam int unsigned EW    = $bits(slot_entry_type);

   req_word_type         req_ff, req_in;
   logic [LW-1:0]        lst_ff, lst_in;
   logic [SW-1:0]        slt_ff, slt_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [NUM_LISTS-1:0] alive_ff, alive_in;
   logic [LW-1:0]        alloc_idx_ff, alloc_idx_in;
   logic                 full_ff, full_in;
   logic                 hit_ff, hit_in;
   logic [31:0]          prod_ff, prod_in;
   slot_entry_type       ent_ff, ent_in;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 li_ok, addr_ok;
   logic [31:0]          q_addr_wide;
   logic [AW-1:0]        q_addr;
   logic [LW-1:0]        li_lst;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   slot_entry_type       ram_wr_ent, rd_ent;
   logic [EW-1:0]        ram_rd_data;

   logic [15:0]          mul_a, mul_b;
   logic [25:0]          ph_sum;
   logic [PHASE_W-1:0]   ph_sat;
   logic [8:0]           ph_hi;
   slot_entry_type       tick_ent;

   // addressing of the captured request
   assign li_ok       = 32'(req_ff.list_index) < NUM_LISTS;
   assign addr_ok     = li_ok && (32'(req_ff.slot) < SLOTS_PER_LIST);
   assign q_addr_wide = 32'(req_ff.list_index) * SLOTS_PER_LIST + 32'(req_ff.slot);
   assign q_addr      = addr_ok ? q_addr_wide[AW-1:0] : '0;
   assign li_lst      = LW'(req_ff.list_index);

   // phase update: add, saturate, wrap once by the frame count
   always_comb begin
      ph_sum = {1'b0, ent_ff.phase} + {2'b00, prod_ff[31:8]};
      ph_sat = ph_sum[25] ? PHASE_MAX : ph_sum[PHASE_W-1:0];
      ph_hi  = ph_sat[24:16];
      if (ph_sat[24:16] >= {1'b0, ent_ff.count}) begin
         ph_hi = ph_sat[24:16] - {1'b0, ent_ff.count};
      end
      tick_ent       = ent_ff;
      tick_ent.phase = {ph_hi, ph_sat[15:0]};
   end

   // RAM port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_ent  = '0;
      if (cmd.wr_set) begin
         ram_wr_en         = addr_ok;
         ram_wr_addr       = q_addr;
         ram_wr_ent.size   = req_ff.frm_bytes;
         ram_wr_ent.rate   = req_ff.frm_speed;
         ram_wr_ent.count  = req_ff.frame_count;
      end else if (cmd.wr_tick) begin
         ram_wr_en  = ent_ff.size != 16'd0;
         ram_wr_ent = tick_ent;
      end else if (cmd.wr_zero) begin
         ram_wr_en = 1'b1;
      end
      ram_rd_en   = cmd.rd_query || cmd.rd_tick;
      ram_rd_addr = cmd.rd_query ? q_addr : addr_ff;
   end

   atf_ram #(
      .WIDTH (EW),
      .DEPTH (TOTAL)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (EW'(ram_wr_ent)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_ent = slot_entry_type'(ram_rd_data);

   // shared multiplier operands
   always_comb begin
      if (cmd.mul_query) begin
         mul_a = {7'd0, rd_ent.phase[24:16]};
         mul_b = rd_ent.size;
      end else begin
         mul_a = rd_ent.rate;
         mul_b = req_ff.delta_time;
      end
   end

   always_comb begin
      req_in       = cmd.capture ? req_word_type'(req_tdata) : req_ff;
      lst_in       = lst_ff;
      slt_in       = slt_ff;
      addr_in      = addr_ff;
      alive_in     = alive_ff;
      alloc_idx_in = alloc_idx_ff;
      full_in      = full_ff;
      hit_in       = hit_ff;
      prod_in      = prod_ff;
      ent_in       = ent_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.ld_first) begin
         lst_in       = LW'(1);
         slt_in       = '0;
         addr_in      = AW'(SLOTS_PER_LIST);
         full_in      = 1'b0;
         alloc_idx_in = '0;
      end
      if (cmd.scan_step) begin
         lst_in  = lst_ff + LW'(1);
         addr_in = addr_ff + AW'(SLOTS_PER_LIST);
      end
      if (cmd.slot_step) begin
         addr_in = addr_ff + AW'(1);
         if (status.slt_last) begin
            slt_in = '0;
            lst_in = lst_ff + LW'(1);
         end else begin
            slt_in = slt_ff + SW'(1);
         end
      end
      if (cmd.clr_step) begin
         addr_in = addr_ff + AW'(1);
      end
      if (cmd.alloc_mark) begin
         alive_in[lst_ff] = 1'b1;
         alloc_idx_in     = lst_ff;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.release_list && li_ok) begin
         alive_in[li_lst] = 1'b0;
      end
      if (cmd.mul_query || cmd.mul_tick) begin
         prod_in = 32'(mul_a) * 32'(mul_b);
      end
      if (cmd.mul_query) begin
         hit_in = addr_ok && (rd_ent.size != 16'd0);
      end
      if (cmd.mul_tick) begin
         ent_in = rd_ent;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.done_cmd     = req_ff.cmd;
         case (req_ff.cmd) inside
            CMD_ALLOC:                      rsp_in.result_index = 3'(alloc_idx_ff);
            CMD_SET, CMD_RELEASE, CMD_QUERY: rsp_in.result_index = req_ff.list_index;
            default:                        rsp_in.result_index = 3'd0;
         endcase
         rsp_in.hit        = (req_ff.cmd == CMD_QUERY) && hit_ff;
         rsp_in.tex_ofs    = rsp_in.hit ? prod_ff[PHASE_W-1:0] : '0;
         rsp_in.table_full = (req_ff.cmd == CMD_ALLOC) && full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lst_ff       <= '0;
         slt_ff       <= '0;
         addr_ff      <= '0;
         alive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lst_ff       <= lst_in;
         slt_ff       <= slt_in;
         addr_ff      <= addr_in;
         alive_ff     <= alive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      alloc_idx_ff <= alloc_idx_in;
      full_ff      <= full_in;
      hit_ff       <= hit_in;
      prod_ff      <= prod_in;
      ent_ff       <= ent_in;
      rsp_ff       <= rsp_in;
   end

   assign status.cmd       = req_ff.cmd;
   assign status.addr_ok   = addr_ok;
   assign status.lst_alive = alive_ff[lst_ff];
   assign status.lst_last  = lst_ff == LW'(NUM_LISTS - 1);
   assign status.slt_last  = slt_ff == SW'(SLOTS_PER_LIST - 1);
   assign status.addr_last = addr_ff == AW'(TOTAL - 1);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 40'(rsp_ff);

   // list 0 is reserved and never handed out
   a_list0_dead: assert property (@(posedge clock) disable iff (reset) !alive_ff[0])
      else $error("list 0 marked live");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_set, cmd.wr_zero, cmd.wr_tick}))
      else $error("conflicting RAM writes");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten");

   a_alloc_live: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_mark |=> alive_ff[$past(lst_ff)])
      else $error("allocated list not live");

   a_hit_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> (rsp_ff.done_cmd == CMD_QUERY))
      else $error("hit on a non-query word");

endmodule

`default_nettype wire

// ----- hw/rtl/anim_texture_frame_table.sv -----
// Animated-texture frame table: NUM_LISTS lists of SLOTS_PER_LIST slots, each slot
// holding frame size, Q8.8 frame rate, frame count and a Q9.16 phase, kept in one
// slot RAM. Each request word yields exactly one response word. After reset the
// block runs a clearing pass over the RAM, one entry per cycle, during which
// req_tready stays low. Words are handled one at a time. Set, release and unknown
// codes need no walk; a query reads the RAM, then uses the shared multiplier for
// phase times size; an allocate scans past the live lists, then clears the
// SLOTS_PER_LIST slots of the first dead list, or marks the table full; and a
// tick walks every slot of lists 1 to NUM_LISTS-1, where each slot of a live list
// needs a RAM read, a multiply and a write-back through the single RAM port pair.
// The response sits in its own register, so a new request is taken while it waits.
// Depends on atf_pkg, atf_ctrl, atf_dpath and atf_ram.
`default_nettype none

module anim_texture_frame_table
   import atf_pkg::*;
#(
   parameter int unsigned NUM_LISTS      = 8,
   parameter int unsigned SLOTS_PER_LIST = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[2:0], list_index[5:3], slot[7:6], frm_bytes[23:8],
   // frm_speed[39:24], frame_count[47:40], delta_time[63:48]
   input  wire logic [63:0] req_tdata,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // done_cmd[2:0], result_index[5:3], hit[6], tex_ofs[31:7],
   // table_full[32], zero[39:33]
   output logic      [39:0] rsp_tdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: walks alloc scans, slot clears and the tick sweep
   atf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // storage, counters, multiplier and response register
   atf_dpath #(
      .NUM_LISTS      (NUM_LISTS),
      .SLOTS_PER_LIST (SLOTS_PER_LIST)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire
